// File: rtl/core/tde_pkg.sv
`default_nettype none

package tde_pkg;

    // Default graph size and fixed field widths
    localparam int NODES_DEF = 32;
    localparam int OP_W      = 2;
    localparam int NODE_W    = 5;
    localparam int TRUSS_W   = 6;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR = 2'd0,
        OP_ADD   = 2'd1,
        OP_RUN   = 2'd2,
        OP_QUERY = 2'd3
    } t_op;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_ADD_RD,
        ST_ADD_WA,
        ST_ADD_WB,
        ST_QRY_RD,
        ST_QRY_OUT,
        ST_CP_RD,
        ST_CP_WR,
        ST_SUP_ROW,
        ST_SUP_LATCH,
        ST_SUP_SCAN,
        ST_SUP_AND,
        ST_SUP_CNT,
        ST_PL_ROW,
        ST_PL_LATCH,
        ST_PL_SCAN,
        ST_PL_CHK,
        ST_PL_W,
        ST_PL_DU,
        ST_PL_DV,
        ST_PL_RMU,
        ST_PL_RMV,
        ST_RUN_OUT
    } t_state;

endpackage

`default_nettype wire

// File: rtl/core/tde_ram.sv
`default_nettype none

module tde_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: rtl/core/tde_scan.sv
`default_nettype none

// Find the lowest set bit of a vector
module tde_scan #(
    parameter int WIDTH = 32,
    localparam int IW = (WIDTH > 1) ? $clog2(WIDTH) : 1
) (
    input  logic [WIDTH-1:0] i_vec,
    output logic             o_found,
    output logic [IW-1:0]    o_index
);

    always_comb begin
        o_found = |i_vec;
        o_index = '0;
        for (int i = WIDTH - 1; i >= 0; i--) begin
            if (i_vec[i]) begin
                o_index = IW'(i);
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/truss_decomposition_engine_top.sv
// Clear empties the graph. Add edge reads row a, then sets row a and zeroes its
// trussness, then row b. Query reads row a and the trussness, then gives the result.
// Run copies the graph, counts support per edge, then peels: each pass walks every row
// and edge, updating common neighbors' support; one shared bit scanner sets the pace.
// Throughput: one item at a time, the next item is taken when the engine is idle.
// Reset (synchronous, active low) empties the graph at once through row valid bits.
`default_nettype none

module truss_decomposition_engine_top
    import tde_pkg::*;
#(
    parameter int NODES = NODES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [OP_W-1:0]    i_operation,
    input  logic [NODE_W-1:0]  i_node_a,
    input  logic [NODE_W-1:0]  i_node_b,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [TRUSS_W-1:0] o_truss_value,
    output logic               o_is_edge
);

    localparam int NW = $clog2(NODES);          // node index width
    localparam int PW = 2 * NW;                 // edge (pair) index width
    localparam int PD = 1 << PW;                // support / trussness depth
    localparam int SW = $clog2(NODES);          // support width
    localparam int LW = $clog2(NODES + 1);      // level width
    localparam int CW = $clog2(NODES * NODES);  // remaining edge count width

    // Pair index: smaller node in the upper half
    function automatic logic [PW-1:0] f_pair(input logic [NW-1:0] x, input logic [NW-1:0] y);
        return (x < y) ? {x, y} : {y, x};
    endfunction

    function automatic logic [NODES-1:0] f_bit(input logic [NW-1:0] n);
        return {{(NODES-1){1'b0}}, 1'b1} << n;
    endfunction

    t_state r_state, n_state;

    // Captured item
    logic [NW-1:0] r_a, r_b;
    logic          r_arg_ok;

    // Run datapath
    logic [NW-1:0]    r_u, r_v, r_w;
    logic [NODES-1:0] r_ru, r_rv, r_todo, r_common;
    logic [SW-1:0]    r_cnt;
    logic [CW-1:0]    r_remain;
    logic [LW-1:0]    r_level, r_best;
    logic             r_removed;

    // Original graph row valid bits: a row not valid reads as empty
    logic [NODES-1:0] r_orig_vld;
    logic             r_orig_rvld;

    // Output register
    logic               r_out_vld;
    logic [TRUSS_W-1:0] r_out_truss;
    logic               r_out_edge;

    // Memory ports
    logic             orig_we, work_we, sup_we, tru_we;
    logic [NW-1:0]    orig_waddr, orig_raddr, work_waddr, work_raddr;
    logic [NODES-1:0] orig_wdata, orig_rdata, work_wdata, work_rdata;
    logic [PW-1:0]    sup_waddr, sup_raddr, tru_waddr, tru_raddr;
    logic [SW-1:0]    sup_wdata, sup_rdata;
    logic [LW-1:0]    tru_wdata, tru_rdata;

    logic             w_in_acc, w_out_free, w_arg_ok, w_last_u, w_qualify;
    logic [31:0]      w_a32, w_b32, w_t32;
    logic [NODES-1:0] w_orig_row, w_above, w_scan_vec;
    logic             w_found;
    logic [NW-1:0]    w_idx;
    logic [SW-1:0]    w_sup_dec;
    t_op              w_op;

    assign w_in_acc   = i_in_valid && (r_state == ST_IDLE);
    assign w_out_free = !r_out_vld || !i_out_stall;
    assign w_op       = t_op'(i_operation);
    assign w_a32      = 32'(i_node_a);
    assign w_b32      = 32'(i_node_b);
    assign w_arg_ok   = (w_a32 < NODES) && (w_b32 < NODES) && (i_node_a != i_node_b);
    assign w_orig_row = orig_rdata & {NODES{r_orig_rvld}};
    assign w_last_u   = 32'(r_u) == NODES - 1;
    assign w_qualify  = (32'(sup_rdata) + 32'd2) <= 32'(r_level);
    assign w_sup_dec  = (sup_rdata != '0) ? sup_rdata - 1'b1 : '0;
    assign w_t32      = 32'(tru_rdata);

    // Neighbors above the current row, so each edge is visited once
    always_comb begin
        for (int i = 0; i < NODES; i++) begin
            w_above[i] = 32'(i) > 32'(r_u);
        end
    end

    // One scanner walks edge lists, common neighbors and support counts
    assign w_scan_vec = (r_state == ST_SUP_CNT || r_state == ST_PL_W) ? r_common : r_todo;

    tde_scan #(.WIDTH(NODES)) u_scan (
        .i_vec   (w_scan_vec),
        .o_found (w_found),
        .o_index (w_idx)
    );

    tde_ram #(.WIDTH(NODES), .DEPTH(NODES)) u_orig (
        .i_clk(i_clk), .i_we(orig_we), .i_waddr(orig_waddr), .i_wdata(orig_wdata),
        .i_raddr(orig_raddr), .o_rdata(orig_rdata)
    );

    tde_ram #(.WIDTH(NODES), .DEPTH(NODES)) u_work (
        .i_clk(i_clk), .i_we(work_we), .i_waddr(work_waddr), .i_wdata(work_wdata),
        .i_raddr(work_raddr), .o_rdata(work_rdata)
    );

    tde_ram #(.WIDTH(SW), .DEPTH(PD)) u_sup (
        .i_clk(i_clk), .i_we(sup_we), .i_waddr(sup_waddr), .i_wdata(sup_wdata),
        .i_raddr(sup_raddr), .o_rdata(sup_rdata)
    );

    tde_ram #(.WIDTH(LW), .DEPTH(PD)) u_tru (
        .i_clk(i_clk), .i_we(tru_we), .i_waddr(tru_waddr), .i_wdata(tru_wdata),
        .i_raddr(tru_raddr), .o_rdata(tru_rdata)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    case (w_op)
                        OP_CLEAR: n_state = ST_IDLE;
                        OP_ADD:   n_state = w_arg_ok ? ST_ADD_RD : ST_IDLE;
                        OP_RUN:   n_state = ST_CP_RD;
                        OP_QUERY: n_state = ST_QRY_RD;
                        default:  n_state = ST_IDLE;
                    endcase
                end
            end
            ST_ADD_RD:    n_state = ST_ADD_WA;
            ST_ADD_WA:    n_state = w_orig_row[r_b] ? ST_IDLE : ST_ADD_WB;
            ST_ADD_WB:    n_state = ST_IDLE;
            ST_QRY_RD:    n_state = ST_QRY_OUT;
            ST_QRY_OUT:   n_state = w_out_free ? ST_IDLE : ST_QRY_OUT;
            ST_CP_RD:     n_state = ST_CP_WR;
            ST_CP_WR:     n_state = w_last_u ? ST_SUP_ROW : ST_CP_RD;
            ST_SUP_ROW:   n_state = ST_SUP_LATCH;
            ST_SUP_LATCH: n_state = ST_SUP_SCAN;
            ST_SUP_SCAN: begin
                if (w_found) begin
                    n_state = ST_SUP_AND;
                end else if (!w_last_u) begin
                    n_state = ST_SUP_ROW;
                end else if (r_remain == '0) begin
                    n_state = ST_RUN_OUT;
                end else begin
                    n_state = ST_PL_ROW;
                end
            end
            ST_SUP_AND:   n_state = ST_SUP_CNT;
            ST_SUP_CNT:   n_state = w_found ? ST_SUP_CNT : ST_SUP_SCAN;
            ST_PL_ROW:    n_state = ST_PL_LATCH;
            ST_PL_LATCH:  n_state = ST_PL_SCAN;
            ST_PL_SCAN:   n_state = w_found ? ST_PL_CHK : ST_PL_ROW;
            ST_PL_CHK:    n_state = w_qualify ? ST_PL_W : ST_PL_SCAN;
            ST_PL_W:      n_state = w_found ? ST_PL_DU : ST_PL_RMU;
            ST_PL_DU:     n_state = ST_PL_DV;
            ST_PL_DV:     n_state = ST_PL_W;
            ST_PL_RMU:    n_state = ST_PL_RMV;
            ST_PL_RMV:    n_state = (r_remain == '0) ? ST_RUN_OUT : ST_PL_SCAN;
            ST_RUN_OUT:   n_state = w_out_free ? ST_IDLE : ST_RUN_OUT;
            default:      n_state = ST_IDLE;
        endcase
    end

    // Memory controls
    always_comb begin
        orig_we    = 1'b0;
        orig_waddr = r_a;
        orig_wdata = w_orig_row | f_bit(r_b);
        orig_raddr = r_a;
        work_we    = 1'b0;
        work_waddr = r_u;
        work_wdata = w_orig_row;
        work_raddr = r_u;
        sup_we     = 1'b0;
        sup_waddr  = f_pair(r_u, r_v);
        sup_wdata  = r_cnt;
        sup_raddr  = f_pair(r_u, w_idx);
        tru_we     = 1'b0;
        tru_waddr  = f_pair(r_a, r_b);
        tru_wdata  = '0;
        tru_raddr  = f_pair(r_a, r_b);
        case (r_state)
            ST_ADD_WA: begin
                // New edge: set row a, zero its trussness, fetch row b
                orig_we    = !w_orig_row[r_b];
                tru_we     = !w_orig_row[r_b];
                orig_raddr = r_b;
            end
            ST_ADD_WB: begin
                orig_we    = 1'b1;
                orig_waddr = r_b;
                orig_wdata = w_orig_row | f_bit(r_a);
            end
            ST_CP_RD: begin
                orig_raddr = r_u;
            end
            ST_CP_WR: begin
                work_we = 1'b1;
            end
            ST_SUP_SCAN, ST_PL_SCAN: begin
                work_raddr = w_idx;
            end
            ST_SUP_CNT: begin
                sup_we = !w_found;
            end
            ST_PL_W: begin
                sup_raddr = f_pair(w_idx, r_u);
            end
            ST_PL_DU: begin
                sup_we    = 1'b1;
                sup_waddr = f_pair(r_w, r_u);
                sup_wdata = w_sup_dec;
                sup_raddr = f_pair(r_w, r_v);
            end
            ST_PL_DV: begin
                sup_we    = 1'b1;
                sup_waddr = f_pair(r_w, r_v);
                sup_wdata = w_sup_dec;
            end
            ST_PL_RMU: begin
                work_we    = 1'b1;
                work_waddr = r_u;
                work_wdata = r_ru & ~f_bit(r_v);
                tru_we     = 1'b1;
                tru_waddr  = f_pair(r_u, r_v);
                tru_wdata  = r_level;
            end
            ST_PL_RMV: begin
                work_we    = 1'b1;
                work_waddr = r_v;
                work_wdata = r_rv & ~f_bit(r_u);
            end
            default: begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_orig_vld <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_in_acc && w_op == OP_CLEAR) begin
                r_orig_vld <= '0;
            end else if (orig_we) begin
                r_orig_vld[orig_waddr] <= 1'b1;
            end
            if ((r_state == ST_QRY_OUT || r_state == ST_RUN_OUT) && w_out_free) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_orig_rvld <= r_orig_vld[orig_raddr];
        case (r_state)
            ST_IDLE: begin
                // Hold the pair and its validity for the whole item
                r_a      <= w_a32[NW-1:0];
                r_b      <= w_b32[NW-1:0];
                r_arg_ok <= w_arg_ok;
                r_u      <= '0;
            end
            ST_QRY_OUT: begin
                // Load the answer only once the held result has left
                if (w_out_free) begin
                    r_out_edge  <= r_arg_ok && w_orig_row[r_b];
                    r_out_truss <= (r_arg_ok && w_orig_row[r_b]) ? w_t32[TRUSS_W-1:0] : '0;
                end
            end
            ST_CP_WR: begin
                // Advance the copy; the last row starts the support count
                r_u      <= w_last_u ? '0 : r_u + 1'b1;
                r_remain <= '0;
            end
            ST_SUP_LATCH, ST_PL_LATCH: begin
                r_ru   <= work_rdata;
                r_todo <= work_rdata & w_above;
            end
            ST_SUP_SCAN: begin
                if (w_found) begin
                    r_v            <= w_idx;
                    r_todo[w_idx]  <= 1'b0;
                end else if (!w_last_u) begin
                    r_u <= r_u + 1'b1;
                end else begin
                    r_u       <= '0;
                    r_level   <= LW'(2);
                    r_removed <= 1'b0;
                    r_best    <= LW'(1);
                end
            end
            ST_SUP_AND: begin
                r_common <= r_ru & work_rdata;
                r_cnt    <= '0;
            end
            ST_SUP_CNT: begin
                if (w_found) begin
                    r_common[w_idx] <= 1'b0;
                    r_cnt           <= r_cnt + 1'b1;
                end else begin
                    r_remain <= r_remain + 1'b1;
                end
            end
            ST_PL_SCAN: begin
                if (w_found) begin
                    r_v           <= w_idx;
                    r_todo[w_idx] <= 1'b0;
                end else if (!w_last_u) begin
                    r_u <= r_u + 1'b1;
                end else begin
                    // Pass over: a pass with no removal raises the level
                    r_u       <= '0;
                    r_removed <= 1'b0;
                    if (!r_removed) begin
                        r_level <= r_level + 1'b1;
                    end
                end
            end
            ST_PL_CHK: begin
                r_rv     <= work_rdata;
                r_common <= r_ru & work_rdata;
            end
            ST_PL_W: begin
                if (w_found) begin
                    r_w             <= w_idx;
                    r_common[w_idx] <= 1'b0;
                end
            end
            ST_PL_RMU: begin
                // Drop the edge from the held row and count it out
                r_ru      <= r_ru & ~f_bit(r_v);
                r_remain  <= r_remain - 1'b1;
                r_removed <= 1'b1;
                r_best    <= r_level;
            end
            ST_RUN_OUT: begin
                if (w_out_free) begin
                    r_out_edge  <= 1'b1;
                    r_out_truss <= TRUSS_W'(32'(r_best));
                end
            end
            default: begin
            end
        endcase
    end

    assign o_in_stall    = r_state != ST_IDLE;
    assign o_out_valid   = r_out_vld;
    assign o_truss_value = r_out_truss;
    assign o_is_edge     = r_out_edge;

endmodule

`default_nettype wire

// File: rtl/core/tde_checker.sv
`default_nettype none

module tde_checker
    import tde_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic [OP_W-1:0]    i_operation,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic [TRUSS_W-1:0] o_truss_value,
    input logic               o_is_edge
);

    // A held result keeps its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_truss_value)
            && $stable(o_is_edge))
        else $error("result changed while stalled");

    // A non-edge answer carries no trussness
    a_nonedge_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_is_edge |-> o_truss_value == '0)
        else $error("non-edge result with nonzero value");

    // A run keeps the engine busy after it is taken
    a_run_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && t_op'(i_operation) == OP_RUN |=> o_in_stall)
        else $error("run taken without going busy");

endmodule

bind truss_decomposition_engine_top tde_checker u_tde_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_stall    (o_in_stall),
    .i_operation   (i_operation),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_truss_value (o_truss_value),
    .o_is_edge     (o_is_edge)
);

`default_nettype wire
